// ===== design/pair_list_insert_remove_range_unit_macros.svh =====
// Assertion helpers for the pair list unit.
`ifndef PAIR_LIST_INSERT_REMOVE_RANGE_UNIT_MACROS_SVH
`define PAIR_LIST_INSERT_REMOVE_RANGE_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLIRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define PLIRR_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (cons)) else $error(msg);

`endif

// ===== design/plirr_pkg.sv =====
package plirr_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ELEM_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int END_W    = 4;
    localparam int STAT_W   = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    // Cell update codes.
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD       = 2'd0;
    localparam cell_op_t CELL_LOAD       = 2'd1;
    localparam cell_op_t CELL_FROM_BELOW = 2'd2;
    localparam cell_op_t CELL_FROM_ABOVE = 2'd3;

    typedef struct packed {
        logic signed [ELEM_W-1:0] first;
        logic signed [ELEM_W-1:0] second;
    } pair_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic [POS_W-1:0]  position;
        logic [END_W-1:0]  range_end;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic signed [31:0] out_first;
        logic signed [31:0] out_second;
        logic [CNT_W-1:0]  entry_count;
        logic              is_last;
    } out_word_t;

endpackage

// ===== design/pair_list_insert_remove_range_unit.sv =====
// Ordered list of up to CAPACITY value pairs, held in a row of cells.
// Input channel s_valid/s_ready/s_data carries one command word: append,
// insert at position, remove an inclusive range, or read at position.
// Result channel m_valid/m_ready/m_data carries result words from one
// output register. Append, insert, read and every error give one word,
// registered in the cycle after the command is taken; with m_ready high
// such commands go at one per cycle. A valid removal of n pairs gives n
// words: the command sets the removal state, each step then registers one
// word, one per cycle while m_ready is high; each step reads the cell at
// the range start and shifts every cell above it down by one.
// Insert moves the cells above the position up by one, all at once.
// A new command is taken only when no removal is running and the output
// register is empty or being drained in the same cycle.
// When the receiver stalls, the output register holds its word and the
// unit stops taking commands and removal steps until it drains.
// Reset (aresetn low, synchronous) empties the list and the output
// register; cell contents are left as they are and are never read
// before being written again.
`include "pair_list_insert_remove_range_unit_macros.svh"

module pair_list_insert_remove_range_unit
    import plirr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic STATE_IDLE   = 1'b0;
    localparam logic STATE_REMOVE = 1'b1;

    logic             state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] rem_reg,    rem_next;
    logic [IDX_W-1:0] start_reg,  start_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg,  m_data_next;

    pair_t    cells   [CAPACITY];
    cell_op_t cell_op [CAPACITY];
    pair_t    load_pair;

    logic             out_free;
    logic             accept;
    logic             full;
    logic             ins_bad;
    logic             rm_bad;
    logic             rd_bad;
    logic             step;
    logic [CNT_W-1:0] rm_len;
    logic [CNT_W-1:0] cnt_ext_end;
    logic [POS_W-1:0] pos_ext_end;
    pair_t            read_pair;
    pair_t            start_pair;

    // Output register is free when empty or drained this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == STATE_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign step     = (state_reg == STATE_REMOVE) && out_free;

    assign load_pair.first  = s_data.first_value;
    assign load_pair.second = s_data.second_value;

    assign cnt_ext_end = CNT_W'(s_data.range_end);
    assign pos_ext_end = POS_W'(s_data.range_end);
    assign full        = count_reg >= CNT_W'(CAPACITY);
    assign ins_bad     = CNT_W'(s_data.position) > count_reg;
    assign rm_bad      = (cnt_ext_end >= count_reg) || (s_data.position > pos_ext_end);
    assign rd_bad      = CNT_W'(s_data.position) >= count_reg;
    assign rm_len      = cnt_ext_end - CNT_W'(s_data.position) + CNT_W'(1);

    // Position is below the count whenever a read is valid.
    assign read_pair  = cells[s_data.position[IDX_W-1:0]];
    assign start_pair = cells[start_reg];

    // Per-cell update: load, shift up for insert, shift down for removal.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_op[i] = CELL_HOLD;
            if (accept && s_data.func == FUNC_APPEND && !full) begin
                if (CNT_W'(i) == count_reg) begin
                    cell_op[i] = CELL_LOAD;
                end
            end else if (accept && s_data.func == FUNC_INSERT && !full && !ins_bad) begin
                if (CNT_W'(i) == CNT_W'(s_data.position)) begin
                    cell_op[i] = CELL_LOAD;
                end else if (CNT_W'(i) > CNT_W'(s_data.position) &&
                             CNT_W'(i) <= count_reg) begin
                    cell_op[i] = CELL_FROM_BELOW;
                end
            end else if (step) begin
                if (CNT_W'(i) >= CNT_W'(start_reg)) begin
                    cell_op[i] = CELL_FROM_ABOVE;
                end
            end
        end
    end

    // The row of cells; the top end feeds itself, the bottom takes the load pair.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pair_t below;
        pair_t above;
        if (g == 0) begin : g_bottom
            assign below = load_pair;
        end else begin : g_lower
            assign below = cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_top
            assign above = cells[g];
        end else begin : g_upper
            assign above = cells[g+1];
        end
        plirr_cell u_cell (
            .aclk       (aclk),
            .op         (cell_op[g]),
            .load_pair  (load_pair),
            .below_pair (below),
            .above_pair (above),
            .pair       (cells[g])
        );
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        start_next   = start_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (accept) begin
            m_data_next             = '0;
            m_data_next.is_last     = 1'b1;
            m_data_next.entry_count = count_reg;
            m_valid_next            = 1'b1;
            case (s_data.func)
                FUNC_APPEND: begin
                    if (full) begin
                        m_data_next.status = STATUS_FULL;
                    end else begin
                        count_next              = count_reg + CNT_W'(1);
                        m_data_next.entry_count = count_next;
                    end
                end
                FUNC_INSERT: begin
                    if (full) begin
                        m_data_next.status = STATUS_FULL;
                    end else if (ins_bad) begin
                        m_data_next.status = STATUS_RANGE;
                    end else begin
                        count_next              = count_reg + CNT_W'(1);
                        m_data_next.entry_count = count_next;
                    end
                end
                FUNC_REMOVE: begin
                    if (rm_bad) begin
                        m_data_next.status = STATUS_RANGE;
                    end else begin
                        // Drop the count now; the words follow one per step.
                        count_next   = count_reg - rm_len;
                        rem_next     = rm_len;
                        start_next   = s_data.position[IDX_W-1:0];
                        state_next   = STATE_REMOVE;
                        m_valid_next = 1'b0;
                    end
                end
                FUNC_READ: begin
                    if (rd_bad) begin
                        m_data_next.status = STATUS_RANGE;
                    end else begin
                        m_data_next.out_first  = 32'(read_pair.first);
                        m_data_next.out_second = 32'(read_pair.second);
                    end
                end
                default: begin
                    m_data_next.status = STATUS_RANGE;
                end
            endcase
        end else if (step) begin
            // Emit the pair at the range start; the cells above shift down.
            m_valid_next            = 1'b1;
            m_data_next.status      = STATUS_OK;
            m_data_next.out_first   = 32'(start_pair.first);
            m_data_next.out_second  = 32'(start_pair.second);
            m_data_next.entry_count = count_reg;
            m_data_next.is_last     = (rem_reg == CNT_W'(1));
            rem_next                = rem_reg - CNT_W'(1);
            if (rem_reg == CNT_W'(1)) begin
                state_next = STATE_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_IDLE;
            count_reg   <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg  <= start_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PLIRR_ASSERT(a_count_in_range, count_reg <= CNT_W'(CAPACITY),
        "entry count exceeds capacity")
    `PLIRR_ASSERT(a_remove_has_work, (state_reg == STATE_REMOVE) |-> (rem_reg != '0),
        "removal running with nothing left to emit")
    `PLIRR_ASSERT(a_no_accept_in_remove, (state_reg == STATE_REMOVE) |-> !s_ready,
        "command taken during a removal")
    `PLIRR_ASSERT_NEXT(a_last_step_closes, step && (rem_reg == CNT_W'(1)),
        (state_reg == STATE_IDLE) && m_valid && m_data.is_last,
        "final removal step did not end with a last word")

endmodule

// ===== design/plirr_cell.sv =====
module plirr_cell
    import plirr_pkg::*;
(
    input  logic     aclk,
    input  cell_op_t op,
    input  pair_t    load_pair,
    input  pair_t    below_pair,
    input  pair_t    above_pair,
    output pair_t    pair
);

    pair_t pair_reg;
    pair_t pair_next;

    always_comb begin
        case (op)
            CELL_HOLD:       pair_next = pair_reg;
            CELL_LOAD:       pair_next = load_pair;
            CELL_FROM_BELOW: pair_next = below_pair;
            CELL_FROM_ABOVE: pair_next = above_pair;
            default:         pair_next = pair_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        pair_reg <= pair_next;
    end

    assign pair = pair_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import plirr_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_COMMANDS = 280;
    // The final stretch of random commands runs with no idling on either side.
    localparam int CALM_COMMANDS   = 40;
    // The receiver holds off once, after this many commands, for this many cycles.
    localparam int HOLD_OFF_AT     = 100;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int WATCHDOG_LIMIT  = 2000;
    // Cycles to keep watching after the last owed word, for stray words.
    localparam int TAIL_CYCLES     = 8;

    // One line of the directed table. Rows with typed set carry the single
    // expected word by hand; others are checked against the list predictor.
    // Rows with reps above one repeat the command with fresh random pairs.
    typedef struct {
        in_word_t          cmd;
        int                reps;
        bit                typed;
        logic [STAT_W-1:0] status;
        int                count;
    } stim_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // Predictor state: the pairs the list should hold and how many.
    logic signed [ELEM_W-1:0] shadow_first  [CAPACITY];
    logic signed [ELEM_W-1:0] shadow_second [CAPACITY];
    int                       shadow_count = 0;

    // Words the unit still owes, oldest first.
    out_word_t pending_words [$];
    out_word_t head_word;

    // Hand-typed expectation for the command currently offered.
    bit        cur_typed      = 1'b0;
    out_word_t cur_typed_word = '0;

    int  commands_taken = 0;
    int  words_checked  = 0;
    int  removals       = 0;
    int  rejected       = 0;
    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    bit  calm           = 1'b0;
    bit  holding_off    = 1'b0;

    stim_row_t directed_rows [$];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    pair_list_insert_remove_range_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    task automatic flag_mismatch(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                    words_checked, name, got, want));
    endtask

    // Append one word to the owed list.
    function automatic void queue_word(out_word_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    // Apply one command to the shadow list and queue the words it must give.
    // With emit low only the state advances (the caller queues a typed word).
    function automatic void list_apply(in_word_t c, bit emit);
        int        pos;
        int        rend;
        int        n;
        pair_t     taken [CAPACITY];
        out_word_t w;
        pos  = c.position;
        rend = c.range_end;
        w = '0;
        w.status  = STATUS_OK;
        w.is_last = 1'b1;
        case (c.func)
            FUNC_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    w.status = STATUS_FULL;
                end else begin
                    shadow_first[shadow_count]  = c.first_value;
                    shadow_second[shadow_count] = c.second_value;
                    shadow_count++;
                end
            end
            FUNC_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    w.status = STATUS_FULL;
                end else if (pos > shadow_count) begin
                    w.status = STATUS_RANGE;
                end else begin
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_first[i]  = shadow_first[i-1];
                        shadow_second[i] = shadow_second[i-1];
                    end
                    shadow_first[pos]  = c.first_value;
                    shadow_second[pos] = c.second_value;
                    shadow_count++;
                end
            end
            FUNC_REMOVE: begin
                if (rend >= shadow_count || pos > rend) begin
                    w.status = STATUS_RANGE;
                end else begin
                    n = rend - pos + 1;
                    for (int i = 0; i < n; i++) begin
                        taken[i].first  = shadow_first[pos+i];
                        taken[i].second = shadow_second[pos+i];
                    end
                    for (int i = rend + 1; i < shadow_count; i++) begin
                        shadow_first[i-n]  = shadow_first[i];
                        shadow_second[i-n] = shadow_second[i];
                    end
                    shadow_count -= n;
                    removals++;
                    // One word per removed pair; each carries the count after the removal.
                    if (emit) begin
                        for (int k = 0; k < n; k++) begin
                            w.out_first   = taken[k].first;
                            w.out_second  = taken[k].second;
                            w.entry_count = CNT_W'(shadow_count);
                            w.is_last     = (k == n - 1);
                            queue_word(w);
                        end
                    end
                    return;
                end
            end
            FUNC_READ: begin
                if (pos >= shadow_count) begin
                    w.status = STATUS_RANGE;
                end else begin
                    w.out_first  = shadow_first[pos];
                    w.out_second = shadow_second[pos];
                end
            end
        endcase
        if (w.status != STATUS_OK)
            rejected++;
        w.entry_count = CNT_W'(shadow_count);
        if (emit)
            queue_word(w);
    endfunction

    function automatic stim_row_t row(logic [FUNC_W-1:0] f, logic [31:0] a, logic [31:0] b,
                                      int pos, int rend, int reps, bit typed,
                                      logic [STAT_W-1:0] st, int cnt);
        stim_row_t r;
        r.cmd.func         = f;
        r.cmd.first_value  = a;
        r.cmd.second_value = b;
        r.cmd.position     = POS_W'(pos);
        r.cmd.range_end    = END_W'(rend);
        r.reps             = reps;
        r.typed            = typed;
        r.status           = st;
        r.count            = cnt;
        return r;
    endfunction

    // Mostly plain random values, now and then an extreme.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed commands shaped by the current list length, the rest noise.
    function automatic in_word_t random_command();
        in_word_t c;
        int       sel;
        int       grow;
        int       start;
        int       last_idx;
        c.first_value  = pick_value();
        c.second_value = pick_value();
        c.position     = '0;
        c.range_end    = '0;
        if ($urandom_range(0, 99) < 10) begin
            c.func      = FUNC_W'($urandom_range(0, 3));
            c.position  = POS_W'($urandom_range(0, CAPACITY));
            c.range_end = END_W'($urandom_range(0, CAPACITY - 1));
            return c;
        end
        // Grow the list while short, shrink it while nearly full.
        grow = (shadow_count < 8) ? 60 : (shadow_count >= 14) ? 25 : 45;
        sel  = $urandom_range(0, 99);
        if (sel < grow) begin
            c.func     = sel[0] ? FUNC_APPEND : FUNC_INSERT;
            c.position = POS_W'($urandom_range(0, shadow_count));
        end else if (sel < grow + 25 && shadow_count > 0) begin
            c.func = FUNC_REMOVE;
            if ($urandom_range(0, 9) == 0) begin
                start    = 0;
                last_idx = shadow_count - 1;
            end else begin
                start = $urandom_range(0, shadow_count - 1);
                if (start + 3 < shadow_count)
                    last_idx = start + int'($urandom_range(0, 3));
                else
                    last_idx = int'($urandom_range(start, shadow_count - 1));
            end
            c.range_end = END_W'(last_idx);
            c.position  = POS_W'(start);
        end else begin
            c.func     = FUNC_READ;
            c.position = (shadow_count > 0) ? POS_W'($urandom_range(0, shadow_count - 1))
                                            : '0;
        end
        return c;
    endfunction

    // Drop valid for a random burst of cycles, unless told not to or the receiver holds off.
    task automatic idle_gap(bit allow);
        int gap;
        gap = 0;
        if (allow && !holding_off && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 13);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Call at a falling edge: offer the word and hold it until it is taken.
    task automatic present_command(in_word_t c, bit typed, out_word_t tw);
        s_valid        <= 1'b1;
        s_data         <= c;
        cur_typed      = typed;
        cur_typed_word = tw;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Check result words and advance the predictor on every accepted command.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    flag_mismatch($sformatf("word %0d arrived with nothing outstanding",
                                            words_checked));
                end else begin
                    head_word = pending_words.pop_front();
                    compare_field("status",      m_data.status,      head_word.status);
                    compare_field("out_first",   m_data.out_first,   head_word.out_first);
                    compare_field("out_second",  m_data.out_second,  head_word.out_second);
                    compare_field("entry_count", m_data.entry_count, head_word.entry_count);
                    compare_field("is_last",     m_data.is_last,     head_word.is_last);
                end
                words_checked++;
            end
            if (s_valid && s_ready) begin
                commands_taken++;
                if (cur_typed) begin
                    list_apply(s_data, 1'b0);
                    queue_word(cur_typed_word);
                end else begin
                    list_apply(s_data, 1'b1);
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Receiver: random stall bursts, one long hold-off so the unit backs up
    // into its input, and no stalls in the final stretch.
    initial begin
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!held && commands_taken >= HOLD_OFF_AT) begin
                held        = 1'b1;
                holding_off = 1'b1;
                stall_left  = HOLD_OFF_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                holding_off = 1'b0;
                m_ready <= 1'b1;
            end
        end
    end

    // End the run if nothing moves on either channel for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("Watchdog: no handshake for %0d cycles, %0d words outstanding",
                 WATCHDOG_LIMIT, pending_words.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        in_word_t  cmd;
        out_word_t typed_word;

        // Empty-list errors, extremes of the values, a full list, position 16,
        // the widest removal, and reads and removals checked by the predictor.
        directed_rows = '{
            row(FUNC_READ,   0,            0,            0,  0, 1, 1, STATUS_RANGE, 0),
            row(FUNC_REMOVE, 0,            0,            0,  0, 1, 1, STATUS_RANGE, 0),
            row(FUNC_INSERT, 0,            0,            1,  0, 1, 1, STATUS_RANGE, 0),
            row(FUNC_APPEND, 32'h7fffffff, 32'h80000000, 0,  0, 1, 1, STATUS_OK,    1),
            row(FUNC_INSERT, 32'h80000000, 32'h7fffffff, 0,  0, 1, 1, STATUS_OK,    2),
            row(FUNC_INSERT, 32'h00001234, 32'hfffffffb, 2,  0, 1, 1, STATUS_OK,    3),
            row(FUNC_READ,   0,            0,            0,  0, 1, 0, STATUS_OK,    0),
            row(FUNC_READ,   0,            0,            2,  0, 1, 0, STATUS_OK,    0),
            row(FUNC_READ,   0,            0,            3,  0, 1, 1, STATUS_RANGE, 3),
            row(FUNC_REMOVE, 0,            0,            2,  1, 1, 1, STATUS_RANGE, 3),
            row(FUNC_REMOVE, 0,            0,            0,  3, 1, 1, STATUS_RANGE, 3),
            row(FUNC_REMOVE, 0,            0,            1,  1, 1, 0, STATUS_OK,    0),
            row(FUNC_INSERT, 0,            0,            1,  0, 7, 0, STATUS_OK,    0),
            row(FUNC_APPEND, 0,            0,            0,  0, 7, 0, STATUS_OK,    0),
            row(FUNC_APPEND, 32'h00000001, 32'h00000002, 0,  0, 1, 1, STATUS_FULL,  16),
            row(FUNC_INSERT, 32'h00000003, 32'h00000004, 3,  0, 1, 1, STATUS_FULL,  16),
            row(FUNC_READ,   0,            0,            16, 0, 1, 1, STATUS_RANGE, 16),
            row(FUNC_READ,   0,            0,            15, 0, 1, 0, STATUS_OK,    0),
            row(FUNC_REMOVE, 0,            0,            0, 15, 1, 0, STATUS_OK,    0),
            row(FUNC_APPEND, 32'hffffffff, 32'hffffffff, 0,  0, 1, 1, STATUS_OK,    1),
            row(FUNC_APPEND, 0,            0,            0,  0, 1, 1, STATUS_OK,    2),
            row(FUNC_INSERT, 32'h55555555, 32'haaaaaaaa, 16, 0, 1, 1, STATUS_RANGE, 2),
            row(FUNC_READ,   0,            0,            1,  0, 1, 0, STATUS_OK,    0),
            row(FUNC_REMOVE, 0,            0,            0,  1, 1, 0, STATUS_OK,    0)
        };

        // Hold reset, then release it at a falling edge.
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                idle_gap(1'b1);
                @(negedge aclk);
                cmd = directed_rows[r].cmd;
                if (directed_rows[r].reps > 1) begin
                    cmd.first_value  = pick_value();
                    cmd.second_value = pick_value();
                end
                typed_word             = '0;
                typed_word.status      = directed_rows[r].status;
                typed_word.entry_count = CNT_W'(directed_rows[r].count);
                typed_word.is_last     = 1'b1;
                present_command(cmd, directed_rows[r].typed, typed_word);
            end
        end

        // Build each random command at the falling edge, after the predictor
        // has taken the previous one, so it sees the current list length.
        for (int i = 0; i < RANDOM_COMMANDS; i++) begin
            calm = (i >= RANDOM_COMMANDS - CALM_COMMANDS);
            idle_gap(!calm);
            @(negedge aclk);
            cmd = random_command();
            present_command(cmd, 1'b0, '0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain what is owed, then watch a few more cycles for stray words.
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d commands (%0d removals, %0d rejected), checked %0d result words",
                 commands_taken, removals, rejected, words_checked);
        $display("Receiver held off %0d cycles once; %0d mismatches",
                 HOLD_OFF_CYCLES, mismatch_count);
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
